>>> rtl/core/spd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_pkg
// Shared types, constants and helpers of the series payload decoder.
// ----------------------------------------------------------------------------
package spd_pkg;

   localparam int MAX_SAMPLES_DEF = 4096;
   localparam int RSP_DEPTH       = 4;

   localparam logic [31:0] SCHEMA_V2    = 32'd2;
   localparam logic [31:0] SERIES_MAGIC = 32'h32535241;
   localparam logic [31:0] ENCODING_V   = 32'd1;
   localparam logic [31:0] MODE_UNIFORM = 32'd1;
   localparam logic [31:0] MODE_EXPLICIT = 32'd2;
   localparam logic [15:0] HEADER_BYTES = 16'd24;
   localparam logic [63:0] I64_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;

   localparam logic [3:0] ST_OK     = 4'd0;
   localparam logic [3:0] ST_ARGS   = 4'd1;
   localparam logic [3:0] ST_SHORT  = 4'd2;
   localparam logic [3:0] ST_MAGIC  = 4'd3;
   localparam logic [3:0] ST_HEADER = 4'd4;
   localparam logic [3:0] ST_MODE   = 4'd5;
   localparam logic [3:0] ST_BODY   = 4'd6;
   localparam logic [3:0] ST_RANGE  = 4'd7;
   localparam logic [3:0] ST_LENGTH = 4'd8;

   typedef enum logic [1:0] {
      REG_START    = 2'd0,
      REG_EXPECTED = 2'd1,
      REG_SCHEMA   = 2'd2,
      REG_LENGTH   = 2'd3
   } cfg_reg_type;

   typedef struct packed {
      logic signed [63:0] origin;
      logic [12:0]        expected;
      logic [31:0]        schema;
      logic [15:0]        length;
   } cfg_type;

   typedef struct packed {
      logic               kind;
      logic signed [63:0] ts_ms;
      logic signed [31:0] sample_val;
      logic [3:0]         status;
      logic               last;
   } rsp_type;

   // first error wins
   function automatic logic [3:0] flag(input logic [3:0] cur, input logic [3:0] code);
      flag = (cur == ST_OK) ? code : cur;
   endfunction

endpackage

>>> rtl/core/spd_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/core/spd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_fifo
// Result queue taking up to two beats per cycle, one out per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module spd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push0,
   input  spd_pkg::rsp_type d0,
   input  logic             push1,
   input  spd_pkg::rsp_type d1,
   output logic             room2,
   output logic             out_valid,
   input  logic             out_ready,
   output spd_pkg::rsp_type dout
);

   localparam int PW = $clog2(spd_pkg::RSP_DEPTH);
   localparam int CW = $clog2(spd_pkg::RSP_DEPTH + 1);

   spd_pkg::rsp_type mem_ff [spd_pkg::RSP_DEPTH];
   logic [PW-1:0] wr_ff, rd_ff;
   logic [CW-1:0] cnt_ff;
   logic          pop;

   assign pop       = out_valid && out_ready;
   assign out_valid = (cnt_ff != '0);
   assign dout      = mem_ff[rd_ff];
   assign room2     = (cnt_ff <= CW'(spd_pkg::RSP_DEPTH - 2));

   always_ff @(posedge clock) begin
      if (push0) begin
         mem_ff[wr_ff] <= d0;
      end
      if (push1) begin
         mem_ff[wr_ff + PW'(1)] <= d1;
      end
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_ff + PW'(push0) + PW'(push1);
         rd_ff  <= rd_ff + PW'(pop);
         cnt_ff <= cnt_ff + CW'(push0) + CW'(push1) - CW'(pop);
      end
   end

endmodule

>>> rtl/core/spd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spd_core
// Per-byte header parse, checks, bitmap store and sample generation.
// ----------------------------------------------------------------------------
module spd_core #(
   parameter int MAX_SAMPLES = spd_pkg::MAX_SAMPLES_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_acc,
   input  logic [7:0]       in_byte,
   input  logic             in_last,
   input  spd_pkg::cfg_type cfg,
   output logic             push0,
   output spd_pkg::rsp_type d0,
   output logic             push1,
   output spd_pkg::rsp_type d1
);

   localparam int MAP_DEPTH = (MAX_SAMPLES + 7) / 8;
   localparam int AW = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
   localparam int IW = $clog2(MAX_SAMPLES + 1);

   logic [15:0]   pos_ff, pos_in;
   logic [63:0]   shift_ff, shift_in;
   logic [31:0]   mode_ff, mode_in, intv_ff, intv_in, total_ff, total_in, bm_ff, bm_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [63:0]   rt_ff, rt_in;
   logic [3:0]    err_ff, err_in;
   logic [IW+31:0] prod_ff;

   logic          ram_we;
   logic [AW-1:0] ram_waddr;
   logic [7:0]    ram_rdata;

   logic             smp_ok, st_ok;
   spd_pkg::rsp_type smp, st;

   spd_ram #(.WIDTH(8), .DEPTH(MAP_DEPTH)) u_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (in_byte),
      .raddr (AW'(idx_ff >> 3)),
      .rdata (ram_rdata)
   );

   always_comb begin
      logic [63:0] sh;
      logic [31:0] hi, lo;
      logic [3:0]  e;
      logic [63:0] room;
      logic [15:0] rel;
      logic [2:0]  off;
      logic [31:0] bidx;
      logic        miss;
      logic [32:0] mag;
      logic        bad;
      logic [63:0] ts;
      logic [3:0]  code;

      sh   = {in_byte, shift_ff[63:8]};
      hi   = sh[63:32];
      lo   = sh[31:0];
      e    = err_ff;
      room = spd_pkg::I64_MAX - rt_ff;
      rel  = pos_ff - spd_pkg::HEADER_BYTES;
      off  = rel[2:0] - bm_ff[2:0];
      bidx = 32'(idx_ff >> 3);
      miss = (bidx < bm_ff) && (bidx < 32'(MAP_DEPTH)) && ram_rdata[idx_ff[2:0]];
      mag  = {1'b0, ~lo} + 33'd1;
      bad  = 1'b0;
      ts   = '0;
      code = spd_pkg::ST_OK;

      pos_in   = pos_ff;
      shift_in = shift_ff;
      mode_in  = mode_ff;
      intv_in  = intv_ff;
      total_in = total_ff;
      bm_in    = bm_ff;
      idx_in   = idx_ff;
      rt_in    = rt_ff;
      err_in   = err_ff;
      ram_we   = 1'b0;
      ram_waddr = rel[AW-1:0];
      smp_ok   = 1'b0;
      st_ok    = 1'b0;

      if (in_acc) begin
         shift_in = sh;
         if (pos_ff == 16'd0) begin
            rt_in = cfg.origin;
            if (cfg.expected == '0 || cfg.schema != spd_pkg::SCHEMA_V2 ||
                cfg.origin == '0 || cfg.origin[63]) begin
               e = spd_pkg::flag(e, spd_pkg::ST_ARGS);
            end else if (cfg.length < spd_pkg::HEADER_BYTES) begin
               e = spd_pkg::flag(e, spd_pkg::ST_SHORT);
            end
         end
         if (pos_ff == 16'd3 && hi != spd_pkg::SERIES_MAGIC) begin
            e = spd_pkg::flag(e, spd_pkg::ST_MAGIC);
         end
         if (pos_ff == 16'd7)  mode_in  = hi;
         if (pos_ff == 16'd11) intv_in  = hi;
         if (pos_ff == 16'd15) total_in = hi;
         if (pos_ff == 16'd19) bm_in    = hi;
         if (pos_ff == 16'd23 && e == spd_pkg::ST_OK) begin
            if (hi != spd_pkg::ENCODING_V || total_ff == '0 ||
                total_ff != 32'(cfg.expected) || total_ff > 32'(MAX_SAMPLES) ||
                {1'b0, bm_ff} > (({1'b0, total_ff} + 33'd7) >> 3)) begin
               e = spd_pkg::ST_HEADER;
            end else if ({17'b0, cfg.length} < {1'b0, bm_ff} + 33'd24) begin
               e = spd_pkg::ST_SHORT;
            end else if (mode_ff == spd_pkg::MODE_UNIFORM) begin
               if (intv_ff == '0) begin
                  e = spd_pkg::ST_HEADER;
               end else if ({24'b0, cfg.length} !=
                            40'd24 + {8'b0, bm_ff} + {6'b0, total_ff, 2'b0}) begin
                  e = spd_pkg::ST_BODY;
               end else if ({32'b0, intv_ff} > room) begin
                  e = spd_pkg::ST_RANGE;
               end else if (64'(prod_ff) > room) begin
                  e = spd_pkg::ST_RANGE;
               end
            end else if (mode_ff == spd_pkg::MODE_EXPLICIT) begin
               if (intv_ff != '0 || bm_ff != '0) begin
                  e = spd_pkg::ST_HEADER;
               end else if ({24'b0, cfg.length} != 40'd24 + {5'b0, total_ff, 3'b0}) begin
                  e = spd_pkg::ST_BODY;
               end
            end else begin
               e = spd_pkg::ST_MODE;
            end
         end

         if (e == spd_pkg::ST_OK && pos_ff >= spd_pkg::HEADER_BYTES) begin
            if ({16'b0, rel} < bm_ff) begin
               ram_we = ({16'b0, rel} < 32'(MAP_DEPTH));
            end else if (mode_ff == spd_pkg::MODE_UNIFORM && off[1:0] == 2'b11 &&
                         32'(idx_ff) < total_ff) begin
               smp_ok = !miss;
               ts     = rt_ff;
               rt_in  = rt_ff + {32'b0, intv_ff};
               idx_in = idx_ff + IW'(1);
            end else if (mode_ff == spd_pkg::MODE_EXPLICIT && off == 3'b111 &&
                         32'(idx_ff) < total_ff) begin
               if (lo[31]) begin
                  bad = (rt_ff <= {31'b0, mag});
                  ts  = rt_ff - {31'b0, mag};
               end else begin
                  ts  = rt_ff + {32'b0, lo};
                  bad = ({32'b0, lo} > room) || (ts == '0);
               end
               if (bad) begin
                  e = spd_pkg::flag(e, spd_pkg::ST_RANGE);
               end else begin
                  smp_ok = 1'b1;
               end
               idx_in = idx_ff + IW'(1);
            end
         end

         if (pos_ff != 16'hFFFF) pos_in = pos_ff + 16'd1;
         err_in = e;

         if (in_last) begin
            code = e;
            if (code == spd_pkg::ST_OK && {1'b0, pos_ff} + 17'd1 != {1'b0, cfg.length}) begin
               code = spd_pkg::ST_LENGTH;
            end
            st_ok    = 1'b1;
            pos_in   = '0;
            shift_in = '0;
            mode_in  = '0;
            intv_in  = '0;
            total_in = '0;
            bm_in    = '0;
            idx_in   = '0;
            rt_in    = '0;
            err_in   = '0;
         end
      end

      smp = '{kind: 1'b0, ts_ms: ts, sample_val: hi, status: spd_pkg::ST_OK, last: 1'b0};
      st  = '{kind: 1'b1, ts_ms: '0, sample_val: '0, status: code, last: 1'b1};
   end

   assign push0 = smp_ok || st_ok;
   assign d0    = smp_ok ? smp : st;
   assign push1 = smp_ok && st_ok;
   assign d1    = st;

   always_ff @(posedge clock) begin
      prod_ff <= (total_ff[IW-1:0] - IW'(1)) * intv_ff;
      if (reset) begin
         pos_ff   <= '0;
         shift_ff <= '0;
         mode_ff  <= '0;
         intv_ff  <= '0;
         total_ff <= '0;
         bm_ff    <= '0;
         idx_ff   <= '0;
         rt_ff    <= '0;
         err_ff   <= '0;
      end else begin
         pos_ff   <= pos_in;
         shift_ff <= shift_in;
         mode_ff  <= mode_in;
         intv_ff  <= intv_in;
         total_ff <= total_in;
         bm_ff    <= bm_in;
         idx_ff   <= idx_in;
         rt_ff    <= rt_in;
         err_ff   <= err_in;
      end
   end

`ifndef SYNTH
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      st_ok |-> st.status <= spd_pkg::ST_LENGTH)
      else $error("status code out of range");
   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      in_acc && in_last |=> pos_ff == '0 && err_ff == spd_pkg::ST_OK)
      else $error("run not cleared after last beat");
   a_sample_in_body: assert property (@(posedge clock) disable iff (reset)
      smp_ok |-> pos_ff >= spd_pkg::HEADER_BYTES && err_ff == spd_pkg::ST_OK)
      else $error("sample outside body or after error");
`endif

endmodule

>>> rtl/core/series_payload_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// series_payload_decoder
// Time-series payload decoder: header checks, missing map, sample stream.
// ----------------------------------------------------------------------------
// Takes one payload byte per cycle with no stalls of its own. A byte yields
// at most two result beats (a sample and, on tlast, the status); these go
// into a 4-entry result queue, and req_tready is low while that queue has
// fewer than two free slots, so the input rate is set only by the result
// consumer. The missing-sample bitmap lives in a (MAX_SAMPLES+7)/8 x 8 RAM
// read ahead of each sample through its registered port; no clearing pass is needed.
module series_payload_decoder #(
   parameter int MAX_SAMPLES = spd_pkg::MAX_SAMPLES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] data_byte
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // [63:0] sample_time_ms, [95:64] sample_value_milli,
                                     // [99:96] status_code, zero fill
   output logic         rsp_tuser,   // [0] result_kind
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [63:0]  csr_wdata
);

   spd_pkg::cfg_type cfg_ff;
   spd_pkg::rsp_type d0, d1, dout;
   logic push0, push1, room2, in_acc;

   assign in_acc     = req_tvalid && req_tready;
   assign req_tready = room2;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.origin   <= 64'sd1;
         cfg_ff.expected <= '0;
         cfg_ff.schema   <= '0;
         cfg_ff.length   <= '0;
      end else if (csr_we) begin
         unique case (spd_pkg::cfg_reg_type'(csr_index))
            spd_pkg::REG_START:    cfg_ff.origin   <= csr_wdata;
            spd_pkg::REG_EXPECTED: cfg_ff.expected <= csr_wdata[12:0];
            spd_pkg::REG_SCHEMA:   cfg_ff.schema   <= csr_wdata[31:0];
            spd_pkg::REG_LENGTH:   cfg_ff.length   <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   spd_core #(.MAX_SAMPLES(MAX_SAMPLES)) u_core (
      .clock   (clock),
      .reset   (reset),
      .in_acc  (in_acc),
      .in_byte (req_tdata),
      .in_last (req_tlast),
      .cfg     (cfg_ff),
      .push0   (push0),
      .d0      (d0),
      .push1   (push1),
      .d1      (d1)
   );

   spd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push0     (push0),
      .d0        (d0),
      .push1     (push1),
      .d1        (d1),
      .room2     (room2),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .dout      (dout)
   );

   assign rsp_tdata = {4'b0, dout.status, dout.sample_val, dout.ts_ms};
   assign rsp_tuser = dout.kind;
   assign rsp_tlast = dout.last;

endmodule
